// File: hdl/shutter_travel_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Shutter travel controller assertion macros
// Concurrent check wrappers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef SHUTTER_TRAVEL_CONTROLLER_UNIT_MACROS_SVH
`define SHUTTER_TRAVEL_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define STC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stc assertion failed");
`define STC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stc assertion failed");
`else
`define STC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and codes for the shutter travel controller.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int unsigned DIV_W     = 8;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
    localparam int unsigned POS_W     = 4;

    localparam logic [1:0] DRV_STOP = 2'd0;
    localparam logic [1:0] DRV_UP   = 2'd1;
    localparam logic [1:0] DRV_DOWN = 2'd2;

    localparam logic [1:0] REG_FULL_TRAVEL = 2'd0;
    localparam logic [1:0] REG_ENDSTOP     = 2'd1;
    localparam logic [1:0] REG_DEADTIME    = 2'd2;

    typedef enum logic [2:0] {
        ACT_MS_TICK,
        ACT_SEC_TICK,
        ACT_TOGGLE,
        ACT_FULL_UP,
        ACT_FULL_DOWN,
        ACT_GOTO
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_RELAY,
        ST_GAIN,
        ST_CHECK,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic     load_item;
        logic     div_start;
        logic     store_step;
        logic     apply;
        logic     relay;
        logic     check;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_div;
    } dp_status_t;

endpackage

// File: hdl/shutter_travel_controller_unit.sv
// Flow: an input transfer passes the apply, relay, check and emit states to a
// registered result; an early stop that needs the position credit first runs
// the serial divider. The next input is taken only after the result is emitted;
// a result held by the receiver holds off the next input transfer.
// Reset: synchronous, active low; state cleared, registers back to 120, 120, 10.
// ----------------------------------------------------------------------------
// shutter_travel_controller_unit
// Time-based shutter controller with up and down relay, position estimate,
// endstop timeout and relay deadtime.
// ----------------------------------------------------------------------------
module shutter_travel_controller_unit #(
    parameter int unsigned POSITION_STEPS = 10
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [7:0] s_target_position,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_relay_drive,
    output logic [3:0] m_position,
    output logic       m_moving,
    output logic       m_save_position
);
    import stc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    stc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    stc_dp #(
        .POSITION_STEPS (POSITION_STEPS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_action          (s_action),
        .s_target_position (s_target_position),
        .cmd               (cmd),
        .status            (status),
        .m_relay_drive     (m_relay_drive),
        .m_position        (m_position),
        .m_moving          (m_moving),
        .m_save_position   (m_save_position)
    );

endmodule

// File: hdl/stc_div.sv
// ----------------------------------------------------------------------------
// stc_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [stc_pkg::DIV_W-1:0]  dividend,
    input  logic [stc_pkg::DIV_W-1:0]  divisor,
    output logic                       done,
    output logic [stc_pkg::DIV_W-1:0]  quotient
);
    import stc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W:0]       rem_sh;
    logic [DIV_W:0]       rem_sub;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next = rem_sub[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/stc_dp.sv
// ----------------------------------------------------------------------------
// stc_dp
// Datapath: configuration, position and relay state, result registers.
// ----------------------------------------------------------------------------
`include "shutter_travel_controller_unit_macros.svh"

module stc_dp #(
    parameter int unsigned POSITION_STEPS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [7:0]           cfg_wdata,
    input  logic [2:0]           s_action,
    input  logic [7:0]           s_target_position,
    input  stc_pkg::dp_cmd_t     cmd,
    output stc_pkg::dp_status_t  status,
    output logic [1:0]           m_relay_drive,
    output logic [3:0]           m_position,
    output logic                 m_moving,
    output logic                 m_save_position
);
    import stc_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POSITION_STEPS);

    logic [7:0]       ftt_reg, ftt_next;
    logic [7:0]       endstop_reg, endstop_next;
    logic [7:0]       dead_cfg_reg, dead_cfg_next;

    logic [POS_W-1:0] cur_reg, cur_next;
    logic [POS_W-1:0] goal_reg, goal_next;
    logic [7:0]       ttg_reg, ttg_next;
    logic [1:0]       drive_reg, drive_next;
    logic [1:0]       last_dir_reg, last_dir_next;
    logic [7:0]       on_reg, on_next;
    logic             pend_reg, pend_next;
    logic [7:0]       dead_reg, dead_next;
    logic [1:0]       relay_reg, relay_next;
    logic             save_reg, save_next;
    logic [7:0]       step_reg, step_next;
    logic [2:0]       act_reg;
    logic [7:0]       tgt_reg;

    logic [7:0]       step_lut [256];

    logic             div_done;
    logic [DIV_W-1:0] div_quo;

    logic             plan_en;
    logic [POS_W-1:0] plan_goal;
    logic [POS_W-1:0] tgt_sat;
    logic [8:0]       full_sum;
    logic [11:0]      prod;
    logic [11:0]      travel;
    logic [7:0]       gained;
    logic [8:0]       pos_sum;

    for (genvar i = 0; i < 256; i++) begin : g_step_lut
        assign step_lut[i] = 8'(i / POSITION_STEPS);
    end

    stc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (on_reg),
        .divisor  (step_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign status.div_done = div_done;
    assign status.need_div = pend_reg && (drive_reg == DRV_STOP) && (ttg_reg != '0)
                             && (on_reg < ttg_reg) && (step_reg != '0);

    assign tgt_sat  = (tgt_reg > {4'b0, POS_MAX}) ? POS_MAX : tgt_reg[POS_W-1:0];
    assign full_sum = {1'b0, ftt_reg} + {2'b0, ftt_reg[7:1]};
    assign gained   = (step_reg != '0) ? div_quo : '0;
    assign pos_sum  = {5'b0, cur_reg} + {1'b0, gained};

    always_comb begin
        ftt_next      = ftt_reg;
        endstop_next  = endstop_reg;
        dead_cfg_next = dead_cfg_reg;
        cur_next      = cur_reg;
        goal_next     = goal_reg;
        ttg_next      = ttg_reg;
        drive_next    = drive_reg;
        last_dir_next = last_dir_reg;
        on_next       = on_reg;
        pend_next     = pend_reg;
        dead_next     = dead_reg;
        relay_next    = relay_reg;
        save_next     = save_reg;
        step_next     = step_reg;
        plan_en       = 1'b0;
        plan_goal     = '0;
        prod          = '0;
        travel        = '0;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FULL_TRAVEL: ftt_next      = cfg_wdata;
                REG_ENDSTOP:     endstop_next  = cfg_wdata;
                REG_DEADTIME:    dead_cfg_next = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd.load_item) begin
            save_next = 1'b0;
        end

        if (cmd.store_step) begin
            step_next = step_lut[ftt_reg];
        end

        if (cmd.apply) begin
            unique case (action_t'(act_reg))
                ACT_MS_TICK: begin
                    if (dead_reg != '0) dead_next = dead_reg - 1'b1;
                end
                ACT_SEC_TICK: begin
                    if (drive_reg != DRV_STOP && on_reg != 8'hFF) on_next = on_reg + 1'b1;
                end
                ACT_TOGGLE: begin
                    if (drive_reg == DRV_STOP) begin
                        plan_en = 1'b1;
                        if (last_dir_reg == DRV_UP) begin
                            last_dir_next = DRV_DOWN;
                            plan_goal     = '0;
                        end else begin
                            last_dir_next = DRV_UP;
                            plan_goal     = POS_MAX;
                        end
                    end else begin
                        drive_next = DRV_STOP;
                        pend_next  = 1'b1;
                    end
                end
                ACT_FULL_UP: begin
                    plan_en   = 1'b1;
                    plan_goal = POS_MAX;
                end
                ACT_FULL_DOWN: begin
                    plan_en   = 1'b1;
                    plan_goal = '0;
                end
                ACT_GOTO: begin
                    plan_en   = 1'b1;
                    plan_goal = tgt_sat;
                end
                default: ;
            endcase

            if (plan_en) begin
                if (plan_goal == cur_reg) begin
                    ttg_next = '0;
                end else begin
                    if (plan_goal == POS_MAX || plan_goal == '0) begin
                        travel     = {3'b0, full_sum};
                        drive_next = (plan_goal == '0) ? DRV_DOWN : DRV_UP;
                    end else if (plan_goal > cur_reg) begin
                        prod       = {8'b0, plan_goal - cur_reg} * {4'b0, step_reg};
                        travel     = prod;
                        drive_next = DRV_UP;
                    end else begin
                        prod       = {8'b0, cur_reg - plan_goal} * {4'b0, step_reg};
                        travel     = prod;
                        drive_next = DRV_DOWN;
                    end
                    ttg_next  = (travel > 12'd255) ? 8'hFF : travel[7:0];
                    goal_next = plan_goal;
                    pend_next = 1'b1;
                end
            end
        end

        if (cmd.relay && pend_reg) begin
            if (drive_reg == DRV_STOP) begin
                relay_next = DRV_STOP;
                dead_next  = dead_cfg_reg;
                if (ttg_reg != '0 && on_reg < ttg_reg) begin
                    if (last_dir_reg == DRV_UP) begin
                        cur_next  = (pos_sum > {5'b0, POS_MAX}) ? POS_MAX : pos_sum[POS_W-1:0];
                        goal_next = cur_next;
                        ttg_next  = '0;
                        save_next = 1'b1;
                    end else if (last_dir_reg == DRV_DOWN) begin
                        cur_next  = (gained >= {4'b0, cur_reg}) ? '0
                                    : cur_reg - gained[POS_W-1:0];
                        goal_next = cur_next;
                        ttg_next  = '0;
                        save_next = 1'b1;
                    end
                end
                on_next   = '0;
                pend_next = 1'b0;
            end else if (dead_reg == '0) begin
                relay_next = drive_reg;
                dead_next  = dead_cfg_reg;
                pend_next  = 1'b0;
            end
        end

        if (cmd.check) begin
            // target reached, then endstop timeout
            if (drive_reg != DRV_STOP && on_reg >= ttg_reg) begin
                cur_next      = goal_reg;
                ttg_next      = '0;
                last_dir_next = drive_reg;
                drive_next    = DRV_STOP;
                pend_next     = 1'b1;
                on_next       = '0;
                save_next     = 1'b1;
            end
            if (drive_next != DRV_STOP && on_next >= endstop_reg) begin
                cur_next      = (drive_next == DRV_UP) ? POS_MAX : '0;
                ttg_next      = '0;
                last_dir_next = drive_next;
                drive_next    = DRV_STOP;
                pend_next     = 1'b1;
                on_next       = '0;
                save_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ftt_reg      <= 8'd120;
            endstop_reg  <= 8'd120;
            dead_cfg_reg <= 8'd10;
            cur_reg      <= '0;
            goal_reg     <= '0;
            ttg_reg      <= '0;
            drive_reg    <= DRV_STOP;
            last_dir_reg <= DRV_STOP;
            on_reg       <= '0;
            pend_reg     <= 1'b0;
            dead_reg     <= '0;
            relay_reg    <= DRV_STOP;
            save_reg     <= 1'b0;
            step_reg     <= '0;
        end else begin
            ftt_reg      <= ftt_next;
            endstop_reg  <= endstop_next;
            dead_cfg_reg <= dead_cfg_next;
            cur_reg      <= cur_next;
            goal_reg     <= goal_next;
            ttg_reg      <= ttg_next;
            drive_reg    <= drive_next;
            last_dir_reg <= last_dir_next;
            on_reg       <= on_next;
            pend_reg     <= pend_next;
            dead_reg     <= dead_next;
            relay_reg    <= relay_next;
            save_reg     <= save_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= s_action;
            tgt_reg <= s_target_position;
        end
        if (cmd.emit) begin
            m_relay_drive   <= relay_reg;
            m_position      <= cur_reg;
            m_moving        <= (drive_reg != DRV_STOP);
            m_save_position <= save_reg;
        end
    end

    `STC_ASSERT_IMP(a_relay_code, aclk, aresetn, 1'b1, relay_reg <= DRV_DOWN)
    `STC_ASSERT_IMP(a_pos_range, aclk, aresetn, 1'b1, cur_reg <= POS_MAX && goal_reg <= POS_MAX)
    `STC_ASSERT_IMP(a_relay_dead, aclk, aresetn, relay_reg != $past(relay_reg), dead_reg == dead_cfg_reg)

endmodule

// File: hdl/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl
// Item sequencer: handshakes and datapath commands.
// ----------------------------------------------------------------------------
`include "shutter_travel_controller_unit_macros.svh"

module stc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output stc_pkg::dp_cmd_t     cmd,
    input  stc_pkg::dp_status_t  status
);
    import stc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item  = 1'b1;
                    cmd.store_step = 1'b1;
                    state_next     = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_RELAY;
            end
            ST_RELAY: begin
                if (status.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_GAIN;
                end else begin
                    cmd.relay  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_GAIN: begin
                if (status.div_done) begin
                    cmd.relay  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

    `STC_ASSERT_IMP(a_emit_src, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_EMIT)
    `STC_ASSERT_NXT(a_accept_apply, aclk, aresetn, s_valid && s_ready, state_reg == ST_APPLY)
    `STC_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shutter travel controller testbench
// Streams tick and move commands through the controller with random idle
// gaps on both channels, predicts relay drive, position, moving and the save
// pulse for every transfer, and checks each result against that prediction.
// Register settings change between phases while the controller is idle.
// ----------------------------------------------------------------------------
module testbench;

    import stc_pkg::*;

    localparam int unsigned STEPS       = 10;
    localparam int unsigned LIMIT       = 2_000_000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam logic [2:0]  ACT_SPARE_A = 3'd6;
    localparam logic [2:0]  ACT_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] target;
    } shutter_cmd_t;

    typedef struct packed {
        logic [1:0] relay;
        logic [3:0] pos;
        logic       moving;
        logic       save;
    } shutter_status_t;

    logic       aclk              = 1'b0;
    logic       aresetn           = 1'b0;
    logic       cfg_wr_en         = 1'b0;
    logic [1:0] cfg_addr          = '0;
    logic [7:0] cfg_wdata         = '0;
    logic       s_valid           = 1'b0;
    logic       s_ready;
    logic [2:0] s_action          = '0;
    logic [7:0] s_target_position = '0;
    logic       m_valid;
    logic       m_ready           = 1'b0;
    logic [1:0] m_relay_drive;
    logic [3:0] m_position;
    logic       m_moving;
    logic       m_save_position;

    shutter_cmd_t    pending_cmds[$];
    shutter_status_t expected_status[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned cmds_queued = 0;
    int unsigned hold_req    = 0;
    int unsigned hold_ack    = 0;

    // register mirror
    logic [7:0] cfg_travel  = 8'd120;
    logic [7:0] cfg_endstop = 8'd120;
    logic [7:0] cfg_dead    = 8'd10;

    // controller state mirror
    logic [3:0] pos_est      = '0;
    logic [3:0] goal_pos     = '0;
    logic [7:0] travel_secs  = '0;
    logic [1:0] drive_dir    = DRV_STOP;
    logic [1:0] prev_dir     = DRV_STOP;
    logic [7:0] on_secs      = '0;
    logic       change_req   = 1'b0;
    logic [7:0] dead_left    = '0;
    logic [1:0] relay_mirror = DRV_STOP;

    shutter_travel_controller_unit #(
        .POSITION_STEPS(STEPS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_target_position(s_target_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_relay_drive    (m_relay_drive),
        .m_position       (m_position),
        .m_moving         (m_moving),
        .m_save_position  (m_save_position)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] secs_per_step();
        return cfg_travel / 8'(STEPS);
    endfunction

    function automatic void aim_shutter(int unsigned goal);
        int unsigned span;
        if (goal == pos_est) begin
            travel_secs = '0;
            return;
        end
        if (goal == STEPS || goal == 0) begin
            span = (int'(cfg_travel) * 3) / 2;
            drive_dir = (goal == 0) ? DRV_DOWN : DRV_UP;
        end else if (goal > pos_est) begin
            span = (goal - pos_est) * secs_per_step();
            drive_dir = DRV_UP;
        end else begin
            span = (pos_est - goal) * secs_per_step();
            drive_dir = DRV_DOWN;
        end
        if (span > 255) span = 255;
        travel_secs = span[7:0];
        goal_pos = goal[3:0];
        change_req = 1'b1;
    endfunction

    function automatic void settle_at(logic [3:0] spot, inout logic saved);
        pos_est = spot;
        travel_secs = '0;
        prev_dir = drive_dir;
        drive_dir = DRV_STOP;
        change_req = 1'b1;
        on_secs = '0;
        saved = 1'b1;
    endfunction

    function automatic void update_relays(inout logic saved);
        logic [7:0]  per_step;
        logic [7:0]  gained;
        int unsigned lifted;
        if (change_req) begin
            if (drive_dir == DRV_STOP) begin
                relay_mirror = DRV_STOP;
                dead_left = cfg_dead;
                if (travel_secs != 0 && on_secs < travel_secs) begin
                    per_step = secs_per_step();
                    gained = (per_step != 0) ? on_secs / per_step : 8'd0;
                    if (prev_dir == DRV_UP) begin
                        lifted = pos_est + gained;
                        if (lifted > STEPS) lifted = STEPS;
                        pos_est = lifted[3:0];
                        goal_pos = pos_est;
                        travel_secs = '0;
                        saved = 1'b1;
                    end else if (prev_dir == DRV_DOWN) begin
                        pos_est = (gained >= pos_est) ? 4'd0 : pos_est - gained[3:0];
                        goal_pos = pos_est;
                        travel_secs = '0;
                        saved = 1'b1;
                    end
                end
                on_secs = '0;
                change_req = 1'b0;
            end else if (dead_left == 0) begin
                relay_mirror = drive_dir;
                dead_left = cfg_dead;
                change_req = 1'b0;
            end
        end
        if (drive_dir != DRV_STOP && on_secs >= travel_secs)
            settle_at(goal_pos, saved);
        if (drive_dir != DRV_STOP && on_secs >= cfg_endstop)
            settle_at((drive_dir == DRV_UP) ? 4'(STEPS) : 4'd0, saved);
    endfunction

    function automatic shutter_status_t predict_status(shutter_cmd_t cmd);
        logic            saved;
        shutter_status_t status;
        saved = 1'b0;
        case (cmd.action)
            ACT_MS_TICK: begin
                if (dead_left != 0) dead_left--;
            end
            ACT_SEC_TICK: begin
                if (drive_dir != DRV_STOP && on_secs != 8'd255) on_secs++;
            end
            ACT_TOGGLE: begin
                if (drive_dir == DRV_STOP) begin
                    if (prev_dir == DRV_UP) begin
                        prev_dir = DRV_DOWN;
                        aim_shutter(0);
                    end else begin
                        prev_dir = DRV_UP;
                        aim_shutter(STEPS);
                    end
                end else begin
                    drive_dir = DRV_STOP;
                    change_req = 1'b1;
                end
            end
            ACT_FULL_UP:   aim_shutter(STEPS);
            ACT_FULL_DOWN: aim_shutter(0);
            ACT_GOTO:      aim_shutter((cmd.target > STEPS) ? STEPS : cmd.target);
            default: ;
        endcase
        update_relays(saved);
        status.relay  = relay_mirror;
        status.pos    = pos_est;
        status.moving = (drive_dir != DRV_STOP);
        status.save   = saved;
        return status;
    endfunction

    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= 10) $display("%0t %s", $time, msg);
    endtask

    task automatic queue_cmd(logic [2:0] act, logic [7:0] tgt);
        pending_cmds.push_back('{action: act, target: tgt});
        cmds_queued++;
    endtask

    task automatic queue_run(logic [2:0] act, int unsigned count);
        repeat (count) queue_cmd(act, 8'($urandom));
    endtask

    task automatic queue_move();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)      queue_cmd(ACT_TOGGLE, 8'($urandom));
        else if (r < 40) queue_cmd(ACT_FULL_UP, 8'($urandom));
        else if (r < 55) queue_cmd(ACT_FULL_DOWN, 8'($urandom));
        else if (r < 85) queue_cmd(ACT_GOTO, 8'($urandom_range(0, STEPS)));
        else             queue_cmd(ACT_GOTO, 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_burst();
        int unsigned len;
        int unsigned r;
        len = $urandom_range(4, 40);
        if ($urandom_range(0, 9) < 6) queue_move();
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 50)      queue_cmd(ACT_SEC_TICK, 8'($urandom));
            else if (r < 88) queue_cmd(ACT_MS_TICK, 8'($urandom));
            else if (r < 96) queue_move();
            else             queue_cmd(r[0] ? ACT_SPARE_A : ACT_SPARE_B, 8'($urandom));
        end
    endtask

    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || expected_status.size() != 0 || s_valid || m_valid);
    endtask

    task automatic program_regs(logic [7:0] travel, logic [7:0] endstop, logic [7:0] dead);
        wait_quiet();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_FULL_TRAVEL;
        cfg_wdata <= travel;
        cfg_travel = travel;
        @(posedge aclk);
        cfg_addr  <= REG_ENDSTOP;
        cfg_wdata <= endstop;
        cfg_endstop = endstop;
        @(posedge aclk);
        cfg_addr  <= REG_DEADTIME;
        cfg_wdata <= dead;
        cfg_dead = dead;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_random_phase(int unsigned count);
        int unsigned start;
        start = cmds_queued;
        while (cmds_queued - start < count) begin
            queue_burst();
            if ($urandom_range(0, 9) == 0) wait_quiet();
        end
    endtask

    // sender
    int unsigned send_gap  = 0;
    int unsigned send_calm = 0;

    always @(posedge aclk) begin : driver
        shutter_cmd_t next_cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_status.push_back(predict_status('{action: s_action,
                                                           target: s_target_position}));
            if (s_valid && !s_ready) begin
                // hold until transfer
            end else if (send_gap != 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                next_cmd = pending_cmds.pop_front();
                s_valid           <= 1'b1;
                s_action          <= next_cmd.action;
                s_target_position <= next_cmd.target;
                send_gap = pick_gap(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    int unsigned recv_stall = 0;
    int unsigned recv_calm  = 0;
    int unsigned recv_hold  = 0;

    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            recv_hold = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (recv_hold != 0) begin
            recv_hold--;
            m_ready <= 1'b0;
        end else if (recv_stall != 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            recv_stall = pick_gap(recv_calm);
        end
    end

    always @(posedge aclk) begin : monitor
        shutter_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                log_error($sformatf("unexpected result: relay %0d position %0d moving %0b save %0b",
                                    m_relay_drive, m_position, m_moving, m_save_position));
            end else begin
                want = expected_status.pop_front();
                if (m_relay_drive !== want.relay || m_position !== want.pos ||
                    m_moving !== want.moving || m_save_position !== want.save)
                    log_error($sformatf({"mismatch (expected/actual): relay %0d/%0d ",
                                         "position %0d/%0d moving %0b/%0b save %0b/%0b"},
                                        want.relay, m_relay_drive, want.pos, m_position,
                                        want.moving, m_moving, want.save, m_save_position));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned r;
        logic [7:0]  travel;
        logic [7:0]  endstop;
        logic [7:0]  dead;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait_quiet();

        // idle ticks, spare codes, move to current position, start, reversal, early stop
        queue_cmd(ACT_MS_TICK, 8'h00);
        queue_cmd(ACT_SEC_TICK, 8'hFF);
        queue_cmd(ACT_SPARE_A, 8'hA5);
        queue_cmd(ACT_SPARE_B, 8'h5A);
        queue_cmd(ACT_GOTO, 8'd0);
        queue_cmd(ACT_TOGGLE, 8'h00);
        queue_run(ACT_SEC_TICK, 3);
        queue_cmd(ACT_FULL_DOWN, 8'hFF);
        queue_run(ACT_MS_TICK, 10);
        queue_cmd(ACT_SEC_TICK, 8'h00);
        queue_cmd(ACT_TOGGLE, 8'hFF);
        queue_cmd(ACT_GOTO, 8'd13);
        queue_cmd(ACT_GOTO, 8'd255);

        // saturated full travel time, longest endstop, no deadtime
        program_regs(8'd170, 8'd255, 8'd0);
        queue_run(ACT_MS_TICK, 12);
        queue_cmd(ACT_FULL_DOWN, 8'h00);
        queue_run(ACT_SEC_TICK, 256);
        queue_cmd(ACT_GOTO, 8'd1);
        queue_run(ACT_SEC_TICK, 20);
        queue_cmd(ACT_GOTO, 8'd9);
        queue_run(ACT_SEC_TICK, 40);
        queue_cmd(ACT_TOGGLE, 8'h00);
        run_random_phase(40);

        // shortest endstop, longest deadtime
        program_regs(8'd10, 8'd1, 8'd255);
        queue_cmd(ACT_FULL_UP, 8'h00);
        queue_run(ACT_MS_TICK, 260);
        queue_run(ACT_SEC_TICK, 3);
        queue_cmd(ACT_TOGGLE, 8'h00);
        run_random_phase(40);

        // zero step time
        program_regs(8'd5, 8'd40, 8'd3);
        queue_cmd(ACT_GOTO, 8'd4);
        queue_run(ACT_MS_TICK, 4);
        queue_cmd(ACT_FULL_UP, 8'h00);
        queue_run(ACT_MS_TICK, 4);
        queue_run(ACT_SEC_TICK, 3);
        queue_cmd(ACT_TOGGLE, 8'h00);
        run_random_phase(60);

        for (phase = 0; phase < 8; phase++) begin
            r = $urandom_range(0, 99);
            travel = (r < 10) ? 8'($urandom_range(0, 9)) : 8'($urandom_range(10, 40));
            r = $urandom_range(0, 99);
            endstop = (r < 15) ? 8'd1 : (r < 25) ? 8'd255 : 8'($urandom_range(2, 60));
            dead = ($urandom_range(0, 99) < 20) ? 8'd0 : 8'($urandom_range(1, 6));
            program_regs(travel, endstop, dead);
            if (phase == 2) hold_req++;
            run_random_phase(80);
        end

        wait_quiet();
        repeat (40) @(posedge aclk);
        if (expected_status.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_status.size()));
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/stc_pkg.sv
hdl/stc_div.sv
hdl/stc_dp.sv
hdl/stc_ctrl.sv
hdl/shutter_travel_controller_unit.sv
bench/testbench.sv
